### sv/ckpb_pkg.sv
// ----------------------------------------------------------------------------
// Colour-keyed pixel blend package
// Shared types and constants: pixel and result transactions, blend modes,
// register indexes and the constants of the fixed-point divide.
// ----------------------------------------------------------------------------
`default_nettype none

package ckpb_pkg;

    // Blend modes as held in the blend_mode register.
    typedef enum logic [2:0] {
        MODE_REPLACE    = 3'd0,
        MODE_ADD        = 3'd1,
        MODE_MULTIPLY   = 3'd2,
        MODE_SUBTRACT   = 3'd3,
        MODE_LIGHTEN    = 3'd4,
        MODE_DARKEN     = 3'd5,
        MODE_DIFFERENCE = 3'd6,
        MODE_UNUSED     = 3'd7
    } blend_mode_t;

    // Configuration register indexes.
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_BLEND_MODE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_RED    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY_GREEN  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KEY_BLUE   = 3'd4;

    localparam logic [6:0] ALPHA_FULL = 7'd100;

    // The blend numerator is scaled to a common divisor of 25500 = 4 * 6375.
    // Quotient = ((n >> 2) * RECIP_6375) >> RECIP_SHIFT, exact below SAT_LIMIT.
    localparam logic [20:0]        RECIP_6375  = 21'd1347441;
    localparam int unsigned        RECIP_SHIFT = 33;
    localparam logic signed [24:0] SAT_LIMIT   = 25'sd6528000;

    // One input transaction.
    typedef struct packed {
        logic [7:0] img_red;
        logic [7:0] img_green;
        logic [7:0] img_blue;
        logic [7:0] msk_red;
        logic [7:0] msk_green;
        logic [7:0] msk_blue;
        logic       on_border;
    } pixel_t;

    // One result transaction.
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       blended;
    } result_t;

    // Blend controls shared by the three colour channels.
    typedef struct packed {
        blend_mode_t mode;
        logic [6:0]  alpha;
        logic [6:0]  beta;
    } blend_ctrl_t;

endpackage

`default_nettype wire

### sv/color_keyed_pixel_blend_core.sv
// A result strobes once its accept bit has passed through valid_a_reg, valid_b_reg,
// valid_c_reg and valid_d_reg, and is taken at the edge that ends the strobe.
// Throughput: one pixel per clock; busy stays low and start is taken in every cycle.
// The four stages are the input register, the operand multiplies, the scaled
// numerator and the reciprocal divide. The receiver cannot stall the pipeline.
// Reset clears the stage valid bits and sets the registers to mode add,
// alpha 0 and key colour black.
// ----------------------------------------------------------------------------
// Colour-keyed pixel blend core
// Blends an image pixel with a mask pixel in one of seven modes, passing the
// image through on the border, in the unused mode or where the mask matches the key colour.
// ----------------------------------------------------------------------------
`default_nettype none

module color_keyed_pixel_blend_core
    import ckpb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire pixel_t               pixel,
    output logic                      result_valid,
    output result_t                   result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data
);

    // Configuration registers.
    logic [2:0] mode_reg;
    logic [6:0] alpha_reg;
    logic [7:0] key_red_reg;
    logic [7:0] key_green_reg;
    logic [7:0] key_blue_reg;

    // Pipeline control.
    logic       valid_a_reg;
    logic       valid_b_reg;
    logic       valid_c_reg;
    logic       valid_d_reg;
    logic       pass_b_reg;
    logic       pass_c_reg;
    logic       pass_d_reg;
    pixel_t     pix_a_reg;

    logic        accept;
    logic        keyed;
    logic        pass_a;
    logic [6:0]  alpha_sat;
    blend_ctrl_t ctrl;
    logic [7:0]  red_value;
    logic [7:0]  green_value;
    logic [7:0]  blue_value;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_ADD;
            alpha_reg     <= '0;
            key_red_reg   <= '0;
            key_green_reg <= '0;
            key_blue_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BLEND_MODE: mode_reg      <= cfg_data[2:0];
                REG_ALPHA:      alpha_reg     <= cfg_data[6:0];
                REG_KEY_RED:    key_red_reg   <= cfg_data;
                REG_KEY_GREEN:  key_green_reg <= cfg_data;
                REG_KEY_BLUE:   key_blue_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Input register for the pixel transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_a_reg <= pixel;
        end
    end

    // Key match, border and unused mode all pass the image through.
    assign keyed = (pix_a_reg.msk_red == key_red_reg) &&
                   (pix_a_reg.msk_green == key_green_reg) &&
                   (pix_a_reg.msk_blue == key_blue_reg);
    assign pass_a = pix_a_reg.on_border | keyed | (mode_reg == MODE_UNUSED);

    // Alpha above 100 saturates to full weight on the image.
    assign alpha_sat  = (alpha_reg > ALPHA_FULL) ? ALPHA_FULL : alpha_reg;
    assign ctrl.mode  = blend_mode_t'(mode_reg);
    assign ctrl.alpha = alpha_sat;
    assign ctrl.beta  = ALPHA_FULL - alpha_sat;

    // Valid bits and the pass flag travel alongside the channel data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            pass_b_reg  <= 1'b0;
            pass_c_reg  <= 1'b0;
            pass_d_reg  <= 1'b0;
        end
        else
        begin
            valid_a_reg <= accept;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
            pass_b_reg  <= pass_a;
            pass_c_reg  <= pass_b_reg;
            pass_d_reg  <= pass_c_reg;
        end
    end

    // One datapath per colour channel.
    ckpb_channel u_red
    (
        .clk   (clk),
        .ctrl  (ctrl),
        .img   (pix_a_reg.img_red),
        .msk   (pix_a_reg.msk_red),
        .pass  (pass_a),
        .value (red_value)
    );

    ckpb_channel u_green
    (
        .clk   (clk),
        .ctrl  (ctrl),
        .img   (pix_a_reg.img_green),
        .msk   (pix_a_reg.msk_green),
        .pass  (pass_a),
        .value (green_value)
    );

    ckpb_channel u_blue
    (
        .clk   (clk),
        .ctrl  (ctrl),
        .img   (pix_a_reg.img_blue),
        .msk   (pix_a_reg.msk_blue),
        .pass  (pass_a),
        .value (blue_value)
    );

    assign result_valid     = valid_d_reg;
    assign result.out_red   = red_value;
    assign result.out_green = green_value;
    assign result.out_blue  = blue_value;
    assign result.blended   = ~pass_d_reg;

`ifndef SYNTHESIS
    // A result taken at an edge always matches an earlier accepted transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start, 4))
        else $error("result strobe without a matching transaction");

    // A border pixel is never blended.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && $past(pixel.on_border, 4)) |-> !result.blended)
        else $error("border pixel was blended");

    // A pixel that is passed through keeps the image colour.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.blended) |->
            (result.out_red == $past(pixel.img_red, 4)) &&
            (result.out_green == $past(pixel.img_green, 4)) &&
            (result.out_blue == $past(pixel.img_blue, 4)))
        else $error("pass-through pixel does not match the image pixel");
`endif

endmodule

`default_nettype wire

### sv/ckpb_channel.sv
// ----------------------------------------------------------------------------
// Colour-keyed pixel blend, one colour channel
// Three register stages: operand products, scaled numerator, exact divide
// by 25500 with saturation and the pass-through selection.
// ----------------------------------------------------------------------------
`default_nettype none

module ckpb_channel
    import ckpb_pkg::*;
(
    input  wire logic        clk,
    input  wire blend_ctrl_t ctrl,
    input  wire logic [7:0]  img,
    input  wire logic [7:0]  msk,
    input  wire logic        pass,
    output logic [7:0]       value
);

    // Stage B registers.
    logic signed [17:0] lin_b_reg;
    logic signed [17:0] lin_b_next;
    logic [14:0]        fac_b_reg;
    logic [14:0]        fac_b_next;
    logic               mul_b_reg;
    logic [7:0]         img_b_reg;
    logic               pass_b_reg;

    // Stage C registers.
    logic signed [24:0] num_c_reg;
    logic signed [24:0] num_c_next;
    logic [7:0]         img_c_reg;
    logic               pass_c_reg;

    // Stage D register.
    logic [7:0]         value_reg;
    logic [7:0]         value_next;

    logic signed [10:0] img_s;
    logic signed [10:0] msk_s;
    logic signed [10:0] other;
    logic signed [7:0]  beta_s;
    logic signed [17:0] beta_x;
    logic [14:0]        alpha_p;
    logic signed [25:0] lin_scaled;
    logic [22:0]        mul_prod;
    logic [20:0]        num_q;
    logic [41:0]        recip_prod;

    // Second operand of the blend for the selected mode.
    always_comb
    begin
        img_s = signed'({3'b000, img});
        msk_s = signed'({3'b000, msk});
        case (ctrl.mode)
            MODE_REPLACE:    other = msk_s;
            MODE_ADD:        other = img_s + msk_s;
            MODE_SUBTRACT:   other = img_s - msk_s;
            MODE_LIGHTEN:    other = (img > msk) ? img_s : msk_s;
            MODE_DARKEN:     other = (img < msk) ? img_s : msk_s;
            MODE_DIFFERENCE: other = (img > msk) ? (img_s - msk_s) : (msk_s - img_s);
            default:         other = '0;
        endcase
    end

    // Weighted sum for the linear modes and the factor for multiply.
    always_comb
    begin
        beta_s     = signed'({1'b0, ctrl.beta});
        beta_x     = 18'(beta_s) * 18'(other);
        alpha_p    = 15'(ctrl.alpha) * 15'(img);
        lin_b_next = signed'({3'b000, alpha_p}) + beta_x;
        fac_b_next = 15'(ctrl.alpha) * 15'd255 + 15'(ctrl.beta) * 15'(msk);
    end

    // Numerator over the common divisor of 25500.
    always_comb
    begin
        lin_scaled = 26'(lin_b_reg) * 26'sd255;
        mul_prod   = 23'(img_b_reg) * 23'(fac_b_reg);
        if (mul_b_reg)
        begin
            num_c_next = signed'({2'b00, mul_prod});
        end
        else
        begin
            num_c_next = signed'(lin_scaled[24:0]);
        end
    end

    // Exact divide by reciprocal, clamped to 0..255, or the pixel passed on.
    always_comb
    begin
        num_q      = num_c_reg[22:2];
        recip_prod = 42'(num_q) * 42'(RECIP_6375);
        if (pass_c_reg)
        begin
            value_next = img_c_reg;
        end
        else if (num_c_reg < 0)
        begin
            value_next = 8'd0;
        end
        else if (num_c_reg >= SAT_LIMIT)
        begin
            value_next = 8'd255;
        end
        else
        begin
            value_next = recip_prod[RECIP_SHIFT+7:RECIP_SHIFT];
        end
    end

    // Data stages move every cycle; validity is tracked by the top level.
    always_ff @(posedge clk)
    begin
        lin_b_reg  <= lin_b_next;
        fac_b_reg  <= fac_b_next;
        mul_b_reg  <= (ctrl.mode == MODE_MULTIPLY);
        img_b_reg  <= img;
        pass_b_reg <= pass;
        num_c_reg  <= num_c_next;
        img_c_reg  <= img_b_reg;
        pass_c_reg <= pass_b_reg;
        value_reg  <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Colour-keyed pixel blend core testbench
// The testbench drives pixel transactions through the core under every blend
// mode and several register settings. It checks each result transaction,
// field by field, against a predictor of its own.
// ----------------------------------------------------------------------------

module tb;

    import ckpb_pkg::*;

    // Clock, reset and the ports of the core.
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    pixel_t               pixel     = '0;
    logic                 result_valid;
    result_t              result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    // Register copies, starting from their reset values.
    blend_mode_t cur_mode  = MODE_ADD;
    logic [6:0]  cur_alpha = '0;
    logic [7:0]  cur_key_r = '0;
    logic [7:0]  cur_key_g = '0;
    logic [7:0]  cur_key_b = '0;

    // Pixels waiting to be sent and blended pixels still to arrive.
    pixel_t  in_pixels[$];
    result_t out_pixels[$];
    int      gap_pct    = 0;
    int      bad_fields = 0;

    color_keyed_pixel_blend_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // One colour channel, in exact integer arithmetic with truncation.
    function automatic logic [7:0] mix_channel(blend_mode_t mode, longint a,
                                               logic [7:0] img, logic [7:0] msk);
        longint p;
        longint m;
        longint b;
        longint num;
        longint div;
        longint q;
        p   = img;
        m   = msk;
        b   = 100 - a;
        div = 100;
        case (mode)
            MODE_REPLACE:    num = a * p + b * m;
            MODE_ADD:        num = a * p + b * (p + m);
            MODE_MULTIPLY:
            begin
                num = a * p * 255 + b * p * m;
                div = 25500;
            end
            MODE_SUBTRACT:   num = a * p + b * (p - m);
            MODE_LIGHTEN:    num = a * p + b * ((m > p) ? m : p);
            MODE_DARKEN:     num = a * p + b * ((m < p) ? m : p);
            MODE_DIFFERENCE: num = a * p + b * ((m > p) ? m - p : p - m);
            default:         num = p * 100;
        endcase
        // Only subtract can go negative; it floors at black.
        if (num < 0)
            q = 0;
        else
            q = num / div;
        if (q > 255)
            q = 255;
        return 8'(q);
    endfunction

    // The blended pixel for one input transaction under the current registers.
    function automatic result_t blend_pixel(pixel_t px);
        result_t r;
        logic    keyed;
        longint  a;
        keyed = (px.msk_red == cur_key_r) && (px.msk_green == cur_key_g) &&
                (px.msk_blue == cur_key_b);
        a = (cur_alpha > ALPHA_FULL) ? longint'(ALPHA_FULL) : longint'(cur_alpha);
        if (px.on_border || keyed || cur_mode == MODE_UNUSED)
        begin
            r.out_red   = px.img_red;
            r.out_green = px.img_green;
            r.out_blue  = px.img_blue;
            r.blended   = 1'b0;
        end
        else
        begin
            r.out_red   = mix_channel(cur_mode, a, px.img_red, px.msk_red);
            r.out_green = mix_channel(cur_mode, a, px.img_green, px.msk_green);
            r.out_blue  = mix_channel(cur_mode, a, px.img_blue, px.msk_blue);
            r.blended   = 1'b1;
        end
        return r;
    endfunction

    function automatic pixel_t make_pixel(logic [7:0] ir, logic [7:0] ig, logic [7:0] ib,
                                          logic [7:0] mr, logic [7:0] mg, logic [7:0] mb,
                                          logic border);
        pixel_t px;
        px.img_red   = ir;
        px.img_green = ig;
        px.img_blue  = ib;
        px.msk_red   = mr;
        px.msk_green = mg;
        px.msk_blue  = mb;
        px.on_border = border;
        return px;
    endfunction

    // A channel level, leaning towards black and full scale.
    function automatic logic [7:0] rand_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 8'h00;
        if (r < 12)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // A random pixel; some masks hit the key colour and some miss it by one bit.
    function automatic pixel_t rand_pixel();
        pixel_t px;
        int     r;
        px = make_pixel(rand_level(), rand_level(), rand_level(),
                        rand_level(), rand_level(), rand_level(),
                        $urandom_range(0, 99) < 10);
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            px.msk_red   = cur_key_r;
            px.msk_green = cur_key_g;
            px.msk_blue  = cur_key_b;
        end
        if (r >= 15 && r < 25)
        begin
            case ($urandom_range(0, 2))
                0:       px.msk_red   = cur_key_r ^ 8'(1 << $urandom_range(0, 7));
                1:       px.msk_green = cur_key_g ^ 8'(1 << $urandom_range(0, 7));
                default: px.msk_blue  = cur_key_b ^ 8'(1 << $urandom_range(0, 7));
            endcase
        end
        return px;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            bad_fields++;
        end
    endfunction

    // One register write transaction; the copy follows at the accepting edge.
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [7:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BLEND_MODE: cur_mode  = blend_mode_t'(data[2:0]);
            REG_ALPHA:      cur_alpha = data[6:0];
            REG_KEY_RED:    cur_key_r = data;
            REG_KEY_GREEN:  cur_key_g = data;
            REG_KEY_BLUE:   cur_key_b = data;
            default:        ;
        endcase
    endtask

    // Waits until every pixel is sent and every blended pixel has arrived.
    task automatic wait_drained();
        do @(negedge clk); while (in_pixels.size() != 0 || start);
        do @(posedge clk); while (out_pixels.size() != 0);
    endtask

    // Driver: presents queued pixels, idling at random, and records each
    // accepted transaction's prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            pixel <= '0;
        end
        else
        begin
            if (start && !busy)
                out_pixels.push_back(blend_pixel(pixel));
            if (!start || !busy)
            begin
                if (in_pixels.size() != 0 && $urandom_range(0, 99) >= gap_pct)
                begin
                    start <= 1'b1;
                    pixel <= in_pixels.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: results change only on rising edges, so the mid-cycle value is
    // the one taken at the edge that ends the cycle.
    always @(negedge clk)
    begin : monitor
        result_t want;
        if (rst_n && result_valid)
        begin
            if (out_pixels.size() == 0)
            begin
                $error("result transaction %h arrived with none outstanding", result);
                bad_fields++;
            end
            else
            begin
                want = out_pixels.pop_front();
                check_field("out_red", want.out_red, result.out_red);
                check_field("out_green", want.out_green, result.out_green);
                check_field("out_blue", want.out_blue, result.out_blue);
                check_field("blended", want.blended, result.blended);
            end
        end
    end

    // Stimulus: directed pixels first, then random phases under new settings.
    initial
    begin
        int alpha_of_mode[8];
        alpha_of_mode = '{0, 100, 127, 1, 99, 50, 0, 101};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: add, alpha 0, black key.
        @(negedge clk);
        in_pixels.push_back(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        in_pixels.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h01, 8'h01, 1'b0));
        in_pixels.push_back(make_pixel(8'h34, 8'h34, 8'h34, 8'h12, 8'h12, 8'h12, 1'b1));
        in_pixels.push_back(make_pixel(8'h80, 8'h40, 8'h20, 8'h00, 8'h00, 8'h01, 1'b0));
        wait_drained();

        // Writes beyond the last register must leave the settings alone.
        for (int i = int'(REG_KEY_BLUE) + 1; i < 2 ** REG_IDX_W; i++)
            write_reg(REG_IDX_W'(i), 8'hFF);
        @(negedge clk);
        in_pixels.push_back(make_pixel(8'h10, 8'h20, 8'h30, 8'h05, 8'h06, 8'h07, 1'b0));
        wait_drained();

        // Every mode, the unused one included, at the alpha extremes and one midpoint.
        for (int m = 0; m < 8; m++)
        begin
            write_reg(REG_BLEND_MODE, 8'(m));
            write_reg(REG_ALPHA, 8'(alpha_of_mode[m]));
            @(negedge clk);
            in_pixels.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hFE, 8'hFE, 1'b0));
            in_pixels.push_back(make_pixel(8'h00, 8'h7F, 8'h80, 8'hFF, 8'h80, 8'h7F, 1'b0));
            wait_drained();
        end

        // Random phases; the sender idles less, then more, then not at all.
        for (int p = 0; p < 16; p++)
        begin
            gap_pct = (p < 6) ? 34 : (p < 11) ? 45 : 0;
            write_reg(REG_BLEND_MODE, {5'($urandom), 3'(p % 8)});
            case (p % 5)
                0:       write_reg(REG_ALPHA, 8'd0);
                1:       write_reg(REG_ALPHA, 8'(ALPHA_FULL));
                2:       write_reg(REG_ALPHA, 8'd127);
                3:       write_reg(REG_ALPHA, 8'($urandom));
                default: write_reg(REG_ALPHA, 8'($urandom_range(1, 99)));
            endcase
            case (p % 4)
                0:
                begin
                    write_reg(REG_KEY_RED, 8'h00);
                    write_reg(REG_KEY_GREEN, 8'h00);
                    write_reg(REG_KEY_BLUE, 8'h00);
                end
                1:
                begin
                    write_reg(REG_KEY_RED, 8'hFF);
                    write_reg(REG_KEY_GREEN, 8'hFF);
                    write_reg(REG_KEY_BLUE, 8'hFF);
                end
                default:
                begin
                    write_reg(REG_KEY_RED, 8'($urandom));
                    write_reg(REG_KEY_GREEN, 8'($urandom));
                    write_reg(REG_KEY_BLUE, 8'($urandom));
                end
            endcase
            @(negedge clk);
            repeat (95) in_pixels.push_back(rand_pixel());
            wait_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (8) @(posedge clk);
        if (bad_fields == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
